// ===== hw/rtl/fault_event_table_defines.svh =====
// Assertion macros for the fault event table checker.
// Depends on nothing; expects clk and rst_n in the using scope.
`ifndef FAULT_EVENT_TABLE_DEFINES_SVH
`define FAULT_EVENT_TABLE_DEFINES_SVH

// same-cycle implication
`define FET_AST_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fault_event_table check failed");

// next-cycle implication
`define FET_AST_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fault_event_table check failed");

`endif

// ===== hw/rtl/fet_pkg.sv =====
// Shared types, constants and helpers for the fault event table.
// Used by fet_cell and fault_event_table.
package fet_pkg;

  localparam int LOG_DEPTH = 16;
  localparam int CODE_BITS = 8;
  localparam int IDX_W     = $clog2(LOG_DEPTH);
  localparam int CNT_W     = $clog2(LOG_DEPTH + 1);
  localparam logic [15:0] HIT_MAX = 16'hFFFF;

  localparam logic [2:0] FN_REPORT = 3'd0;
  localparam logic [2:0] FN_CLEAR  = 3'd1;
  localparam logic [2:0] FN_RECOV  = 3'd2;
  localparam logic [2:0] FN_LOOKUP = 3'd3;
  localparam logic [2:0] FN_FRAME  = 3'd4;
  localparam logic [2:0] FN_CLRALL = 3'd5;
  localparam logic [2:0] FN_TICK   = 3'd6;

  localparam logic [2:0] REC_IDLE  = 3'd0;
  localparam logic [2:0] REC_DET   = 3'd1;
  localparam logic [2:0] REC_BUSY  = 3'd2;
  localparam logic [2:0] REC_DONE  = 3'd3;
  localparam logic [2:0] REC_FAIL  = 3'd4;
  localparam logic [2:0] REC_PERM  = 3'd5;

  localparam logic [1:0] LVL_CRIT  = 2'd3;

  localparam logic [2:0] CELL_NOP   = 3'd0;
  localparam logic [2:0] CELL_SHIFT = 3'd1;
  localparam logic [2:0] CELL_HIT   = 3'd2;
  localparam logic [2:0] CELL_LOAD  = 3'd3;
  localparam logic [2:0] CELL_REC   = 3'd4;
  localparam logic [2:0] CELL_FRAME = 3'd5;

  typedef struct packed {
    logic [CODE_BITS-1:0] code;
    logic [1:0]           level;
    logic [31:0]          stamp;
    logic [15:0]          hits;
    logic [2:0]           rec;
    logic [3:0][15:0]     frame;
  } entry_t;

  typedef struct packed {
    logic [2:0]           op;
    logic [IDX_W-1:0]     pos;
    logic [CODE_BITS-1:0] code;
    logic [1:0]           level;
    logic [31:0]          stamp;
    logic [3:0][15:0]     w;
    logic                 ok;
  } cell_ctl_t;

  function automatic logic [2:0] next_rec(input logic [2:0] s, input logic ok);
    logic [2:0] n;
    n = s;
    case (s)
      REC_IDLE: n = ok ? REC_IDLE : REC_DET;
      REC_DET:  n = ok ? REC_DONE : REC_BUSY;
      REC_BUSY: n = ok ? REC_DONE : REC_FAIL;
      REC_DONE: n = REC_IDLE;
      default:  n = s;
    endcase
    return n;
  endfunction

endpackage

// ===== hw/rtl/fet_cell.sv =====
// One slot of the fault log; takes its right neighbor's entry on a shift.
// Depends on fet_pkg.
module fet_cell import fet_pkg::*; (
  input  logic             clk,
  input  cell_ctl_t        ctl,
  input  logic [IDX_W-1:0] idx,
  input  entry_t           right_i,
  output entry_t           ent_o
);

  entry_t ent_r;

  assign ent_o = ent_r;

  always_ff @(posedge clk) begin
    case (ctl.op)
      CELL_SHIFT: begin
        if (idx >= ctl.pos) ent_r <= right_i;
      end
      CELL_HIT: begin
        if (idx == ctl.pos) begin
          if (ent_r.hits != HIT_MAX) ent_r.hits <= ent_r.hits + 16'd1;
          ent_r.frame[0] <= ctl.w[0];
          ent_r.frame[1] <= ctl.w[1];
          ent_r.stamp    <= ctl.stamp;
        end
      end
      CELL_LOAD: begin
        if (idx == ctl.pos) begin
          ent_r.code     <= ctl.code;
          ent_r.level    <= ctl.level;
          ent_r.stamp    <= ctl.stamp;
          ent_r.hits     <= 16'd1;
          ent_r.rec      <= REC_IDLE;
          ent_r.frame[0] <= ctl.w[0];
          ent_r.frame[1] <= ctl.w[1];
          ent_r.frame[2] <= 16'd0;
          ent_r.frame[3] <= 16'd0;
        end
      end
      CELL_REC: begin
        if (idx == ctl.pos) ent_r.rec <= next_rec(ent_r.rec, ctl.ok);
      end
      CELL_FRAME: begin
        if (idx == ctl.pos) ent_r.frame <= ctl.w;
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== hw/rtl/fault_event_table.sv =====
// Fault event table top level: command FSM driving a row of fet_cell slots.
// Depends on fet_pkg and fet_cell.
//
//  port group | direction | handshake
//  in_*       | in        | start & !busy accepts one item
//  out_*      | out       | out_valid high one cycle, no back-pressure
//
// Steps: after accept, busy through a match state, then a result capture state;
// a new report that appends adds a load state; clear all removes the entries
// one per cycle through the cell shift, then leaves. out_valid is high in
// the first cycle busy is low, and a new item may be accepted in that cycle.
// Reset: synchronous, empties the log and zeroes the clock.
module fault_event_table import fet_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_func,
  input  logic [7:0]  in_fault_code,
  input  logic [1:0]  in_fault_level,
  input  logic [15:0] in_frame_word0,
  input  logic [15:0] in_frame_word1,
  input  logic [15:0] in_frame_word2,
  input  logic [15:0] in_frame_word3,
  input  logic        in_success,
  input  logic [31:0] in_elapsed,
  output logic        out_valid,
  output logic        out_result_flag,
  output logic [2:0]  out_recovery_out,
  output logic [1:0]  out_entry_level,
  output logic [31:0] out_entry_time,
  output logic [15:0] out_entry_hits,
  output logic [15:0] out_frame0,
  output logic [15:0] out_frame1,
  output logic [15:0] out_frame2,
  output logic [15:0] out_frame3,
  output logic [4:0]  out_active_count,
  output logic [1:0]  out_worst_level,
  output logic        out_system_ready
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_OP   = 3'd1;
  localparam logic [2:0] S_APP  = 3'd2;
  localparam logic [2:0] S_CLR  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]           state_r, state_nxt;
  logic [CNT_W-1:0]     fill_r, fill_nxt;
  logic [31:0]          clock_r, clock_nxt;
  logic                 flag_r, flag_nxt;
  logic                 valid_r;

  logic [2:0]           func_r;
  logic [CODE_BITS-1:0] code_r;
  logic [1:0]           level_r;
  logic [3:0][15:0]     w_r;
  logic                 ok_r;
  logic [31:0]          elapsed_r;

  entry_t               ent [LOG_DEPTH];
  entry_t               right [LOG_DEPTH];
  cell_ctl_t            ctl;

  logic                 hit_any, vic_non_crit, clr_any;
  logic [IDX_W-1:0]     hit_idx, vic_idx, clr_idx;
  logic                 any1, any2, any3;
  logic                 full;
  entry_t               sel;

  assign full = (fill_r == CNT_W'(LOG_DEPTH));

  genvar g;
  generate
    for (g = 0; g < LOG_DEPTH; g++) begin : g_cell
      if (g == LOG_DEPTH - 1) begin : g_last
        assign right[g] = '0;
      end else begin : g_mid
        assign right[g] = ent[g+1];
      end
      fet_cell u_cell (
        .clk     (clk),
        .ctl     (ctl),
        .idx     (IDX_W'(g)),
        .right_i (right[g]),
        .ent_o   (ent[g])
      );
    end
  endgenerate

  // first-match searches over the slots in use
  always_comb begin
    hit_any      = 1'b0;
    hit_idx      = '0;
    vic_non_crit = 1'b0;
    vic_idx      = IDX_W'(LOG_DEPTH - 1);
    clr_any      = 1'b0;
    clr_idx      = '0;
    any1 = 1'b0; any2 = 1'b0; any3 = 1'b0;
    for (int i = LOG_DEPTH - 1; i >= 0; i--) begin
      if (CNT_W'(i) < fill_r) begin
        if (code_r != '0 && ent[i].code == code_r) begin
          hit_any = 1'b1;
          hit_idx = IDX_W'(i);
        end
        if (ent[i].level != LVL_CRIT) begin
          vic_non_crit = 1'b1;
          vic_idx      = IDX_W'(i);
        end
        if (ent[i].rec != REC_PERM) begin
          clr_any = 1'b1;
          clr_idx = IDX_W'(i);
        end
        if (ent[i].level == 2'd1) any1 = 1'b1;
        if (ent[i].level == 2'd2) any2 = 1'b1;
        if (ent[i].level == 2'd3) any3 = 1'b1;
      end
    end
  end

  assign sel = hit_any ? ent[hit_idx] : '0;

  always_comb begin
    state_nxt = state_r;
    fill_nxt  = fill_r;
    clock_nxt = clock_r;
    flag_nxt  = flag_r;
    ctl       = '0;
    ctl.code  = code_r;
    ctl.level = level_r;
    ctl.stamp = clock_r;
    ctl.w     = w_r;
    ctl.ok    = ok_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_OP;
        flag_nxt = 1'b0;
      end
      S_OP: begin
        state_nxt = S_OUT;
        case (func_r)
          FN_REPORT: begin
            if (code_r != '0) begin
              if (hit_any) begin
                ctl.op  = CELL_HIT;
                ctl.pos = hit_idx;
              end else begin
                state_nxt = S_APP;
                if (full) begin
                  ctl.op   = CELL_SHIFT;
                  ctl.pos  = vic_non_crit ? vic_idx : IDX_W'(LOG_DEPTH - 1);
                  fill_nxt = fill_r - CNT_W'(1);
                end
              end
            end
          end
          FN_CLEAR: begin
            if (hit_any) begin
              ctl.op   = CELL_SHIFT;
              ctl.pos  = hit_idx;
              fill_nxt = fill_r - CNT_W'(1);
              flag_nxt = 1'b1;
            end
          end
          FN_RECOV: begin
            if (hit_any) begin
              ctl.op  = CELL_REC;
              ctl.pos = hit_idx;
            end
          end
          FN_FRAME: begin
            if (hit_any) begin
              ctl.op  = CELL_FRAME;
              ctl.pos = hit_idx;
            end
          end
          FN_CLRALL: state_nxt = S_CLR;
          FN_TICK:   clock_nxt = clock_r + elapsed_r;
          default: begin
          end
        endcase
      end
      S_APP: begin
        ctl.op    = CELL_LOAD;
        ctl.pos   = fill_r[IDX_W-1:0];
        fill_nxt  = fill_r + CNT_W'(1);
        flag_nxt  = 1'b1;
        state_nxt = S_OUT;
      end
      S_CLR: begin
        if (clr_any) begin
          ctl.op   = CELL_SHIFT;
          ctl.pos  = clr_idx;
          fill_nxt = fill_r - CNT_W'(1);
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fill_r  <= '0;
      clock_r <= '0;
      flag_r  <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      clock_r <= clock_nxt;
      flag_r  <= flag_nxt;
      valid_r <= (state_r == S_OUT);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && start) begin
      func_r    <= in_func;
      code_r    <= in_fault_code[CODE_BITS-1:0];
      level_r   <= in_fault_level;
      w_r[0]    <= in_frame_word0;
      w_r[1]    <= in_frame_word1;
      w_r[2]    <= in_frame_word2;
      w_r[3]    <= in_frame_word3;
      ok_r      <= in_success;
      elapsed_r <= in_elapsed;
    end
    if (state_r == S_OUT) begin
      out_result_flag  <= (func_r == FN_REPORT || func_r == FN_CLEAR) ? flag_r : hit_any;
      out_recovery_out <= sel.rec;
      out_entry_level  <= sel.level;
      out_entry_time   <= sel.stamp;
      out_entry_hits   <= sel.hits;
      out_frame0       <= sel.frame[0];
      out_frame1       <= sel.frame[1];
      out_frame2       <= sel.frame[2];
      out_frame3       <= sel.frame[3];
      out_active_count <= 5'(fill_r);
      out_worst_level  <= any3 ? 2'd3 : any2 ? 2'd2 : any1 ? 2'd1 : 2'd0;
      out_system_ready <= !any3;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = valid_r;

endmodule

// ===== hw/rtl/fet_checker.sv =====
// Port-level checks for fault_event_table, bound to the top level.
// Depends on fault_event_table_defines.svh.
`include "fault_event_table_defines.svh"

module fet_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_valid,
  input logic [4:0] out_active_count,
  input logic [1:0] out_worst_level,
  input logic       out_system_ready
);

  `FET_AST_IMP(a_strobe_idle, out_valid, !busy)
  `FET_AST_NXT(a_accept_busy, start && !busy, busy)
  `FET_AST_NXT(a_strobe_single, out_valid, !out_valid)
  `FET_AST_IMP(a_count_range, out_valid, out_active_count <= 5'd16)
  `FET_AST_IMP(a_ready_worst, out_valid, out_system_ready == (out_worst_level != 2'd3))

endmodule

bind fault_event_table fet_checker u_fet_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .out_valid        (out_valid),
  .out_active_count (out_active_count),
  .out_worst_level  (out_worst_level),
  .out_system_ready (out_system_ready)
);
